/* hdl/cmrv_pkg.sv */
`timescale 1ns / 1ps
package cmrv_pkg;

  localparam int CFG_DW = 31;
  localparam int CFG_IW = 2;

  typedef enum logic [CFG_IW-1:0] {
    REG_VOXEL_SIZE     = 2'd0,
    REG_REPULSION_GAIN = 2'd1,
    REG_TINY_VALUE     = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    CFG_IDLE,
    CFG_SQUARE,
    CFG_TRIPLE,
    CFG_ROOT
  } cfg_state_e;

  typedef struct packed {
    logic signed [31:0] cell_x;
    logic signed [31:0] cell_y;
    logic signed [31:0] cell_z;
    logic signed [31:0] voxel_x;
    logic signed [31:0] voxel_y;
    logic signed [31:0] voxel_z;
    logic [30:0]        cell_radius;
    logic [30:0]        nucleus_radius;
    logic [30:0]        matrix_density;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
  } in_t;

  typedef struct packed {
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic signed [31:0] new_vel_z;
    logic [30:0]        deform_increment;
    logic               applied;
  } out_t;

  typedef struct packed {
    logic [30:0] gain;
    logic [15:0] tiny;
    logic [30:0] ecm_radius;
  } cfg_t;

endpackage

/* hdl/cmrv_isqrt_pipe.sv */
`timescale 1ns / 1ps
module cmrv_isqrt_pipe #(
  parameter int IW = 66,
  parameter int SW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          val_i,
  input  logic [IW-1:0] rad_i,
  input  logic [SW-1:0] side_i,
  output logic          val_o,
  output logic [IW/2-1:0] root_o,
  output logic [SW-1:0] side_o
);

  localparam int NS  = IW / 2;
  localparam int RMW = NS + 3;

  logic [NS-1:0]  vld_q;
  logic [IW-1:0]  rad_q  [NS];
  logic [RMW-1:0] rem_q  [NS];
  logic [NS-1:0]  root_q [NS];
  logic [SW-1:0]  side_q [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic           v_in;
    logic [IW-1:0]  rad_in;
    logic [RMW-1:0] rem_in;
    logic [NS-1:0]  root_in;
    logic [SW-1:0]  side_in;
    logic [RMW-1:0] rem_sh;
    logic [RMW-1:0] trial;

    if (k == 0) begin : g_first
      assign v_in    = val_i;
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = vld_q[k-1];
      assign rad_in  = rad_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign rem_sh = {rem_in[RMW-3:0], rad_in[IW-1 -: 2]};
    assign trial  = {1'b0, root_in, 2'b01};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rad_q[k]  <= rad_in << 2;
      side_q[k] <= side_in;
      if (rem_sh >= trial) begin
        rem_q[k]  <= rem_sh - trial;
        root_q[k] <= {root_in[NS-2:0], 1'b1};
      end else begin
        rem_q[k]  <= rem_sh;
        root_q[k] <= {root_in[NS-2:0], 1'b0};
      end
    end
  end

  assign val_o  = vld_q[NS-1];
  assign root_o = root_q[NS-1];
  assign side_o = side_q[NS-1];

endmodule

/* hdl/cmrv_div_pipe.sv */
`timescale 1ns / 1ps
module cmrv_div_pipe #(
  parameter int DW    = 32,
  parameter int QW    = 17,
  parameter int LANES = 2,
  parameter int SW    = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              val_i,
  input  logic [LANES-1:0][DW+QW-1:0]       num_i,
  input  logic [LANES-1:0][DW-1:0]          den_i,
  input  logic [SW-1:0]                     side_i,
  output logic                              val_o,
  output logic [LANES-1:0][QW-1:0]          quo_o,
  output logic [SW-1:0]                     side_o
);

  logic [QW-1:0]                 vld_q;
  logic [LANES-1:0][DW-1:0]      rem_q  [QW];
  logic [LANES-1:0][QW-1:0]      low_q  [QW];
  logic [LANES-1:0][QW-1:0]      quo_q  [QW];
  logic [LANES-1:0][DW-1:0]      den_q  [QW];
  logic [SW-1:0]                 side_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic                      v_in;
    logic [LANES-1:0][DW-1:0]  rem_in;
    logic [LANES-1:0][QW-1:0]  low_in;
    logic [LANES-1:0][QW-1:0]  quo_in;
    logic [LANES-1:0][DW-1:0]  den_in;
    logic [SW-1:0]             side_in;
    logic [LANES-1:0][DW-1:0]  rem_nx;
    logic [LANES-1:0][QW-1:0]  quo_nx;

    if (k == 0) begin : g_first
      assign v_in    = val_i;
      assign den_in  = den_i;
      assign side_in = side_i;
      assign quo_in  = '0;
      for (genvar l = 0; l < LANES; l++) begin : g_lane
        assign rem_in[l] = num_i[l][DW+QW-1 -: DW];
        assign low_in[l] = num_i[l][QW-1:0];
      end
    end else begin : g_next
      assign v_in    = vld_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign low_in  = low_q[k-1];
      assign quo_in  = quo_q[k-1];
      assign den_in  = den_q[k-1];
      assign side_in = side_q[k-1];
    end

    always_comb begin
      logic [DW:0] rem_sh;
      logic [DW:0] diff;
      for (int l = 0; l < LANES; l++) begin
        rem_sh    = {rem_in[l], low_in[l][QW-1]};
        diff      = rem_sh - {1'b0, den_in[l]};
        rem_nx[l] = diff[DW] ? rem_sh[DW-1:0] : diff[DW-1:0];
        quo_nx[l] = {quo_in[l][QW-2:0], ~diff[DW]};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k]  <= rem_nx;
      quo_q[k]  <= quo_nx;
      den_q[k]  <= den_in;
      side_q[k] <= side_in;
      for (int l = 0; l < LANES; l++) begin
        low_q[k][l] <= low_in[l] << 1;
      end
    end
  end

  assign val_o  = vld_q[QW-1];
  assign quo_o  = quo_q[QW-1];
  assign side_o = side_q[QW-1];

endmodule

/* hdl/cmrv_cfg.sv */
`timescale 1ns / 1ps
module cmrv_cfg import cmrv_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_IW-1:0] cfg_idx_i,
  input  logic [CFG_DW-1:0] cfg_data_i,
  output cfg_t              cfg_o,
  output logic              busy_o
);

  localparam int ROOT_STEPS = 32;
  localparam int CW = $clog2(ROOT_STEPS);
  localparam logic [30:0] VOXEL_RST = 31'(20) << FRAC_BITS;
  localparam logic [30:0] GAIN_RST  = 31'(1) << FRAC_BITS;

  cfg_state_e state_q, state_d;
  logic [30:0]   vs_q;
  logic [30:0]   gain_q;
  logic [15:0]   tiny_q;
  logic [30:0]   ecm_q;
  logic [63:0]   rad_q;
  logic [34:0]   rem_q;
  logic [31:0]   root_q;
  logic [CW-1:0] cnt_q;
  logic          vs_write;
  logic          last_step;
  logic [34:0]   rem_sh;
  logic [34:0]   trial;
  logic          take;

  assign vs_write  = cfg_we_i && (cfg_reg_e'(cfg_idx_i) == REG_VOXEL_SIZE);
  assign last_step = (cnt_q == CW'(ROOT_STEPS - 1));
  assign rem_sh    = {rem_q[32:0], rad_q[63:62]};
  assign trial     = {1'b0, root_q, 2'b01};
  assign take      = (rem_sh >= trial);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      CFG_IDLE:   state_d = CFG_IDLE;
      CFG_SQUARE: state_d = CFG_TRIPLE;
      CFG_TRIPLE: state_d = CFG_ROOT;
      CFG_ROOT: begin
        if (last_step) begin
          state_d = CFG_IDLE;
        end
      end
      default:    state_d = CFG_IDLE;
    endcase
    if (vs_write) begin
      state_d = CFG_SQUARE;
    end
  end

  always_comb begin
    busy_o = (state_q != CFG_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CFG_SQUARE;
      vs_q    <= VOXEL_RST;
      gain_q  <= GAIN_RST;
      tiny_q  <= 16'd1;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_idx_i))
          REG_VOXEL_SIZE:     vs_q   <= cfg_data_i;
          REG_REPULSION_GAIN: gain_q <= cfg_data_i;
          REG_TINY_VALUE:     tiny_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (state_q == CFG_ROOT) begin
        cnt_q <= cnt_q + CW'(1);
      end else begin
        cnt_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      CFG_SQUARE: begin
        rad_q <= 64'(vs_q) * 64'(vs_q);
      end
      CFG_TRIPLE: begin
        rad_q  <= rad_q + {rad_q[62:0], 1'b0};
        rem_q  <= '0;
        root_q <= '0;
      end
      CFG_ROOT: begin
        rad_q  <= rad_q << 2;
        rem_q  <= take ? rem_sh - trial : rem_sh;
        root_q <= {root_q[30:0], take};
        if (last_step) begin
          ecm_q <= root_q[30:0];
        end
      end
      default: ;
    endcase
  end

  assign cfg_o.gain       = gain_q;
  assign cfg_o.tiny       = tiny_q;
  assign cfg_o.ecm_radius = ecm_q;

endmodule

/* hdl/cell_matrix_repulsion_velocity_unit.sv */
`timescale 1ns / 1ps
// Cell to matrix repulsion, one cell and voxel pair per beat. A beat is taken on every clock
// edge with start high and busy low, and its result appears on result_o with result_valid_o
// high for exactly one cycle; results leave in order and cannot be held off. The pipeline
// is the 33-stage distance root, the FRAC_BITS + 1 stage ratio divider and the 31-stage
// velocity divider plus ten register stages. Busy is high after reset and after every
// voxel_size write, while an iterative root recomputes the voxel radius; otherwise a beat
// is taken in every cycle.
module cell_matrix_repulsion_velocity_unit import cmrv_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  in_t               item_i,
  output logic              result_valid_o,
  output out_t              result_o,
  input  logic              cfg_we_i,
  input  logic [CFG_IW-1:0] cfg_idx_i,
  input  logic [CFG_DW-1:0] cfg_data_i
);

  localparam int TW   = FRAC_BITS + 1;
  localparam int RNW  = 32 + TW;
  localparam logic [TW-1:0] ONE = TW'(1) << FRAC_BITS;

  typedef struct packed {
    logic [2:0][32:0] mag;
    logic [2:0]       neg;
    logic [2:0][31:0] vel;
    logic [30:0]      crad;
    logic [30:0]      nrad;
    logic [TW-1:0]    dens;
    logic             lowd;
  } pre_t;

  typedef struct packed {
    logic [2:0][32:0] mag;
    logic [2:0]       neg;
    logic [2:0][31:0] vel;
    logic [TW-1:0]    dens;
    logic [31:0]      span;
    logic             nuc;
    logic             skip;
    logic [30:0]      deform;
  } post_t;

  typedef struct packed {
    logic [2:0]       neg;
    logic [2:0][31:0] vel;
    logic             apply;
    logic [30:0]      deform;
  } fin_t;

  cfg_t cfg;
  logic accept;

  cmrv_cfg #(.FRAC_BITS(FRAC_BITS)) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg),
    .busy_o     (busy)
  );

  assign accept = start && !busy;

  // Stage 1: displacement, clamps.
  pre_t s1_d, s1_q;
  logic v1_q;

  always_comb begin
    logic signed [31:0] cpos [3];
    logic signed [31:0] vpos [3];
    logic signed [32:0] dif;
    cpos[0] = item_i.cell_x;  cpos[1] = item_i.cell_y;  cpos[2] = item_i.cell_z;
    vpos[0] = item_i.voxel_x; vpos[1] = item_i.voxel_y; vpos[2] = item_i.voxel_z;
    for (int i = 0; i < 3; i++) begin
      dif          = 33'(cpos[i]) - 33'(vpos[i]);
      s1_d.neg[i]  = dif[32];
      s1_d.mag[i]  = dif[32] ? 33'(-dif) : 33'(dif);
    end
    s1_d.vel[0] = item_i.vel_x;
    s1_d.vel[1] = item_i.vel_y;
    s1_d.vel[2] = item_i.vel_z;
    s1_d.crad   = item_i.cell_radius;
    s1_d.nrad   = (item_i.nucleus_radius > item_i.cell_radius) ?
                  item_i.cell_radius : item_i.nucleus_radius;
    s1_d.dens   = (item_i.matrix_density > 31'(ONE)) ? ONE : item_i.matrix_density[TW-1:0];
    s1_d.lowd   = (32'(s1_d.dens) <= 32'(cfg.tiny));
  end

  // Stage 2: squares. Stage 3: sum.
  pre_t s2_q, s3_q;
  logic v2_q, v3_q;
  logic [65:0] sq_q [3];
  logic [65:0] sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= accept;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q <= s1_d;
    s2_q <= s1_q;
    for (int i = 0; i < 3; i++) begin
      sq_q[i] <= 66'(s1_q.mag[i]) * 66'(s1_q.mag[i]);
    end
    s3_q  <= s2_q;
    sum_q <= sq_q[0] + sq_q[1] + sq_q[2];
  end

  logic        vr_o;
  logic [32:0] root;
  pre_t        sr;

  cmrv_isqrt_pipe #(.IW(66), .SW($bits(pre_t))) u_dist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .val_i  (v3_q),
    .rad_i  (sum_q),
    .side_i (s3_q),
    .val_o  (vr_o),
    .root_o (root),
    .side_o (sr)
  );

  // Stage 4: floor, overlap tests, deformation.
  post_t s4_q;
  logic  v4_q;
  logic [31:0] dd_q, dnuc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else begin
      v4_q <= vr_o;
    end
  end

  always_ff @(posedge clk_i) begin
    logic [32:0] span;
    logic [15:0] dfloor;
    logic [31:0] dd;
    logic [31:0] dnuc;
    logic [31:0] diff;
    logic        nuc;
    logic        skip;
    dfloor = (cfg.tiny == 16'd0) ? 16'd1 : cfg.tiny;
    span   = (root < 33'(dfloor)) ? 33'(dfloor) : root;
    dd     = 32'(sr.crad) + 32'(cfg.ecm_radius);
    dnuc   = 32'(sr.nrad) + 32'(cfg.ecm_radius);
    nuc    = (span < 33'(dnuc));
    skip   = sr.lowd || (span >= 33'(dd));
    diff   = dnuc - span[31:0];
    s4_q.mag    <= sr.mag;
    s4_q.neg    <= sr.neg;
    s4_q.vel    <= sr.vel;
    s4_q.dens   <= sr.dens;
    s4_q.span   <= span[31:0];
    s4_q.nuc    <= nuc;
    s4_q.skip   <= skip;
    s4_q.deform <= (!nuc || skip) ? '0 : (diff[31] ? '1 : diff[30:0]);
    dd_q   <= dd;
    dnuc_q <= dnuc;
  end

  logic [1:0][RNW-1:0] rnum;
  logic [1:0][31:0]    rden;
  logic [1:0][TW-1:0]  rquo;
  logic                vq_o;
  post_t               sq;

  assign rnum[0] = RNW'(dnuc_q) << FRAC_BITS;
  assign rden[0] = dd_q;
  assign rnum[1] = RNW'(s4_q.span) << FRAC_BITS;
  assign rden[1] = s4_q.nuc ? dnuc_q : dd_q;

  cmrv_div_pipe #(.DW(32), .QW(TW), .LANES(2), .SW($bits(post_t))) u_ratio (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .val_i  (v4_q),
    .num_i  (rnum),
    .den_i  (rden),
    .side_i (s4_q),
    .val_o  (vq_o),
    .quo_o  (rquo),
    .side_o (sq)
  );

  // Stages 5 to 9: shape, density, gain, projection.
  post_t s5_q, s6_q, s7_q, s8_q;
  logic  v5_q, v6_q, v7_q, v8_q, v9_q;
  logic [TW-1:0] a2_q, b2_q, r_q, t_q, td_q;
  logic [30:0]   s_q;
  logic [2:0][62:0] prod_q;
  fin_t          s9_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      v8_q <= 1'b0;
      v9_q <= 1'b0;
    end else begin
      v5_q <= vq_o;
      v6_q <= v5_q;
      v7_q <= v6_q;
      v8_q <= v7_q;
      v9_q <= v8_q;
    end
  end

  always_ff @(posedge clk_i) begin
    logic [TW-1:0]   a;
    logic [TW-1:0]   b;
    logic [2*TW-1:0] pa;
    logic [2*TW-1:0] pb;
    logic [2*TW-1:0] pt;
    logic [2*TW-1:0] pd;
    logic [TW+30:0]  pg;
    a  = ONE - rquo[0];
    b  = ONE - rquo[1];
    pa = (2*TW)'(a) * (2*TW)'(a);
    pb = (2*TW)'(b) * (2*TW)'(b);
    s5_q <= sq;
    a2_q <= pa[FRAC_BITS +: TW];
    b2_q <= pb[FRAC_BITS +: TW];
    r_q  <= rquo[1];

    pt   = (2*TW)'(ONE - a2_q) * (2*TW)'(r_q);
    s6_q <= s5_q;
    t_q  <= s5_q.nuc ? ONE - pt[FRAC_BITS +: TW] : b2_q;

    pd   = (2*TW)'(t_q) * (2*TW)'(s6_q.dens);
    s7_q <= s6_q;
    td_q <= pd[FRAC_BITS +: TW];

    pg   = (TW+31)'(td_q) * (TW+31)'(cfg.gain);
    s8_q <= s7_q;
    s_q  <= pg[FRAC_BITS +: 31];

    for (int i = 0; i < 3; i++) begin
      prod_q[i] <= 63'(s_q) * 63'(s8_q.mag[i]);
    end
    s9_q.neg    <= s8_q.neg;
    s9_q.vel    <= s8_q.vel;
    s9_q.apply  <= (s_q != '0) && !s8_q.skip;
    s9_q.deform <= s8_q.deform;
  end

  logic [2:0][31:0] dden;
  logic [2:0][30:0] delta;
  logic             vd_o;
  fin_t             sd;
  logic [31:0]      s9_dist_q;

  assign dden = {3{s8_q.span}};

  always_ff @(posedge clk_i) begin
    s9_dist_q <= dden[0];
  end

  cmrv_div_pipe #(.DW(32), .QW(31), .LANES(3), .SW($bits(fin_t))) u_delta (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .val_i  (v9_q),
    .num_i  (prod_q),
    .den_i  ({3{s9_dist_q}}),
    .side_i (s9_q),
    .val_o  (vd_o),
    .quo_o  (delta),
    .side_o (sd)
  );

  // Output register: saturating velocity update.
  out_t out_d, out_q;
  logic vo_q;

  always_comb begin
    logic signed [33:0] sum;
    logic signed [33:0] dlt;
    logic [2:0][31:0]   nv;
    for (int i = 0; i < 3; i++) begin
      dlt = sd.neg[i] ? -34'(delta[i]) : 34'(delta[i]);
      sum = 34'($signed(sd.vel[i])) + dlt;
      if (!sd.apply) begin
        nv[i] = sd.vel[i];
      end else if (!sum[33] && (sum[32] || sum[31])) begin
        nv[i] = 32'h7FFF_FFFF;
      end else if (sum[33] && !(sum[32] && sum[31])) begin
        nv[i] = 32'h8000_0000;
      end else begin
        nv[i] = sum[31:0];
      end
    end
    out_d.new_vel_x        = nv[0];
    out_d.new_vel_y        = nv[1];
    out_d.new_vel_z        = nv[2];
    out_d.deform_increment = sd.deform;
    out_d.applied          = sd.apply;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else begin
      vo_q <= vd_o;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign result_valid_o = vo_q;
  assign result_o       = out_q;

endmodule

/* hdl/cmrv_checker.sv */
`timescale 1ns / 1ps
module cmrv_checker import cmrv_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input in_t               item_i,
  input logic              result_valid_o,
  input out_t              result_o,
  input logic              cfg_we_i,
  input logic [CFG_IW-1:0] cfg_idx_i,
  input logic [CFG_DW-1:0] cfg_data_i
);

  localparam int LAT = 75 + FRAC_BITS;

  // Every result belongs to a beat accepted the fixed latency earlier.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start && !busy, LAT))
    else $error("result strobe does not match an accepted beat");

  // Every accepted beat returns its result after the fixed latency.
  a_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##LAT result_valid_o)
    else $error("accepted beat produced no result");

  // A result without repulsion carries the velocity of its own beat.
  a_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.applied |->
      (result_o.new_vel_x == $past(item_i.vel_x, LAT)) &&
      (result_o.new_vel_y == $past(item_i.vel_y, LAT)) &&
      (result_o.new_vel_z == $past(item_i.vel_z, LAT)))
    else $error("velocity changed without repulsion");

  // Voxel size writes start the radius recomputation.
  a_recompute: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && (cfg_idx_i == REG_VOXEL_SIZE) |=> busy)
    else $error("busy not raised after voxel size write");

  // Leaving reset, the radius is recomputed first.
  a_reset_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> busy)
    else $error("busy low right after reset");

endmodule

bind cell_matrix_repulsion_velocity_unit cmrv_checker #(.FRAC_BITS(FRAC_BITS)) u_checker (.*);

/* tb/sv/cell_matrix_repulsion_velocity_unit_tb.sv */
`timescale 1ns / 1ps
module cell_matrix_repulsion_velocity_unit_tb;
  import cmrv_pkg::*;

  localparam logic [CFG_IW-1:0] REG_UNMAPPED = 2'd3;
  localparam logic [63:0] ONE = 64'd1 << 16;
  localparam int unsigned SETTLE_CYCLES = 150;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  in_t               item_i;
  logic              result_valid_o;
  out_t              result_o;
  logic              cfg_we_i;
  logic [CFG_IW-1:0] cfg_idx_i;
  logic [CFG_DW-1:0] cfg_data_i;

  logic [30:0] voxel_size_q;
  logic [30:0] gain_q;
  logic [15:0] tiny_q;

  in_t  pending_beats[$];
  out_t expected_vel_q[$];
  int unsigned gap_left;
  bit          no_idle;
  int unsigned beats_sent;
  int unsigned beats_checked;
  int unsigned applied_seen;
  int unsigned deform_seen;
  int unsigned mismatches;
  int unsigned cfg_writes;

  cell_matrix_repulsion_velocity_unit DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .item_i(item_i),
    .result_valid_o(result_valid_o), .result_o(result_o),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [33:0] floor_root(logic [67:0] v);
    logic [35:0] rem;
    logic [35:0] trial;
    logic [33:0] root;
    rem = '0;
    root = '0;
    for (int i = 33; i >= 0; i--) begin
      rem = (rem << 2) | 36'(v[2*i +: 2]);
      trial = (36'(root) << 2) | 36'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 34'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  function automatic out_t repel_velocity(in_t x);
    logic signed [31:0] cpos[3], vpos[3], vel[3];
    logic signed [32:0] disp[3];
    logic [32:0] mag[3];
    logic [67:0] sumsq;
    logic [63:0] crad, nrad, dens, ecm, dd, dnuc, span, dfloor;
    logic [63:0] t, s, q, a, a2, r, b, deform;
    logic [127:0] prod;
    longint delta, sum;
    out_t o;
    cpos = '{x.cell_x, x.cell_y, x.cell_z};
    vpos = '{x.voxel_x, x.voxel_y, x.voxel_z};
    vel  = '{x.vel_x, x.vel_y, x.vel_z};
    sumsq = '0;
    for (int i = 0; i < 3; i++) begin
      disp[i] = 33'(cpos[i]) - 33'(vpos[i]);
      mag[i] = disp[i][32] ? 33'(-disp[i]) : 33'(disp[i]);
      sumsq = sumsq + 68'(mag[i]) * 68'(mag[i]);
    end
    o.new_vel_x = vel[0];
    o.new_vel_y = vel[1];
    o.new_vel_z = vel[2];
    o.deform_increment = '0;
    o.applied = 1'b0;
    crad = 64'(x.cell_radius);
    nrad = 64'(x.nucleus_radius);
    dens = 64'(x.matrix_density);
    if (dens > ONE) dens = ONE;
    if (dens <= 64'(tiny_q)) return o;
    if (nrad > crad) nrad = crad;
    ecm = 64'(floor_root(68'(3) * 68'(voxel_size_q) * 68'(voxel_size_q))) >> 1;
    dd = crad + ecm;
    dnuc = nrad + ecm;
    dfloor = (tiny_q != 0) ? 64'(tiny_q) : 64'd1;
    span = 64'(floor_root(sumsq));
    if (span < dfloor) span = dfloor;
    if (span >= dd) return o;
    deform = '0;
    if (span < dnuc) begin
      q = (dnuc * ONE) / dd;
      a = ONE - q;
      a2 = (a * a) >> 16;
      r = (span * ONE) / dnuc;
      t = ONE - (((ONE - a2) * r) >> 16);
      deform = dnuc - span;
      if (deform > 64'h7FFF_FFFF) deform = 64'h7FFF_FFFF;
    end else begin
      r = (span * ONE) / dd;
      b = ONE - r;
      t = (b * b) >> 16;
    end
    t = (t * dens) >> 16;
    s = (t * 64'(gain_q)) >> 16;
    o.deform_increment = deform[30:0];
    if (s == 0) return o;
    for (int i = 0; i < 3; i++) begin
      prod = (128'(s) * 128'(mag[i])) / 128'(span);
      delta = longint'(prod[63:0]);
      if (disp[i][32]) delta = -delta;
      sum = longint'(vel[i]) + delta;
      if (sum > 64'sh7FFF_FFFF) sum = 64'sh7FFF_FFFF;
      if (sum < -64'sh8000_0000) sum = -64'sh8000_0000;
      vel[i] = sum[31:0];
    end
    o.new_vel_x = vel[0];
    o.new_vel_y = vel[1];
    o.new_vel_z = vel[2];
    o.applied = 1'b1;
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      item_i <= '0;
      gap_left = 0;
      no_idle = 1'b0;
    end else begin
      if (start && !busy) begin
        expected_vel_q = {expected_vel_q, repel_velocity(item_i)};
        void'(pending_beats.pop_front());
        beats_sent++;
        gap_left = no_idle ? 0 : $urandom_range(0, 12);
        if ($urandom_range(0, 40) == 0) no_idle = !no_idle;
      end
      if (start && busy) begin
        start <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_beats.size() > 0) begin
        start <= 1'b1;
        item_i <= pending_beats[0];
      end else begin
        start <= 1'b0;
      end
    end
  end

  task automatic report_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s mismatch on beat %0d: expected %h, got %h",
                 $realtime, name, beats_checked, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && result_valid_o) begin
      if (expected_vel_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("%0t: unexpected result %h", $realtime, result_o);
      end else begin
        want = expected_vel_q.pop_front();
        report_field("new_vel_x", want.new_vel_x, result_o.new_vel_x);
        report_field("new_vel_y", want.new_vel_y, result_o.new_vel_y);
        report_field("new_vel_z", want.new_vel_z, result_o.new_vel_z);
        report_field("deform_increment", 32'(want.deform_increment),
                     32'(result_o.deform_increment));
        report_field("applied", 32'(want.applied), 32'(result_o.applied));
        if (result_o.applied) applied_seen++;
        if (result_o.deform_increment != 0) deform_seen++;
        beats_checked++;
      end
    end
  end

  task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_VOXEL_SIZE) voxel_size_q = data;
    else if (idx == REG_REPULSION_GAIN) gain_q = data;
    else if (idx == REG_TINY_VALUE) tiny_q = data[15:0];
    cfg_writes++;
  endtask

  task automatic drain;
    while (pending_beats.size() > 0 || start || expected_vel_q.size() > 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic in_t random_pair();
    in_t x;
    int unsigned lvl;
    logic [31:0] mask;
    lvl = $urandom_range(4, 31);
    mask = (32'd1 << lvl) - 1;
    x.voxel_x = $urandom;
    x.voxel_y = $urandom;
    x.voxel_z = $urandom;
    x.cell_x = x.voxel_x + ($urandom & mask) - (mask >> 1);
    x.cell_y = x.voxel_y + ($urandom & mask) - (mask >> 1);
    x.cell_z = x.voxel_z + ($urandom & mask) - (mask >> 1);
    x.cell_radius = 31'($urandom & (mask << 1 | 32'd1));
    x.nucleus_radius = ($urandom_range(0, 3) == 0) ? 31'($urandom) : 31'($urandom & mask);
    x.matrix_density = ($urandom_range(0, 4) == 0) ? 31'($urandom) : 31'($urandom_range(0, 65536));
    x.vel_x = $urandom;
    x.vel_y = $urandom;
    x.vel_z = $urandom;
    if ($urandom_range(0, 5) == 0) begin
      x.vel_x = {$urandom_range(0, 1) ? 1'b1 : 1'b0, {31{$urandom_range(0, 1) ? 1'b0 : 1'b1}}};
      x.vel_y = 32'sh7FFF_FFF0;
      x.vel_z = -32'sh7FFF_FFF0;
    end
    if ($urandom_range(0, 7) == 0) x = ($bits(in_t))'({$urandom, $urandom, $urandom, $urandom,
                                        $urandom, $urandom, $urandom, $urandom, $urandom,
                                        $urandom, $urandom, $urandom});
    return x;
  endfunction

  task automatic queue_directed;
    in_t x;
    x = '0;
    x.matrix_density = 31'd65536;
    pending_beats = {pending_beats, x};
    x.cell_radius = 31'(65536 * 30);
    x.nucleus_radius = 31'(65536 * 10);
    pending_beats = {pending_beats, x};
    x.cell_x = 32'sd65536 * 5;
    x.cell_y = -32'sd65536 * 3;
    pending_beats = {pending_beats, x};
    x.cell_x = 32'sd65536 * 40;
    pending_beats = {pending_beats, x};
    x.nucleus_radius = 31'h7FFF_FFFF;
    pending_beats = {pending_beats, x};
    x.matrix_density = '0;
    pending_beats = {pending_beats, x};
    x.matrix_density = 31'h7FFF_FFFF;
    pending_beats = {pending_beats, x};
    x.matrix_density = 31'd65537;
    x.vel_x = 32'sh7FFF_FFFF;
    x.vel_y = -32'sh8000_0000;
    x.vel_z = -32'sh8000_0000;
    pending_beats = {pending_beats, x};
    x.cell_x = 32'sh7FFF_FFFF;
    x.voxel_x = -32'sh8000_0000;
    x.cell_y = -32'sh8000_0000;
    x.voxel_y = 32'sh7FFF_FFFF;
    x.cell_z = 32'sh7FFF_FFFF;
    x.voxel_z = -32'sh8000_0000;
    x.cell_radius = 31'h7FFF_FFFF;
    pending_beats = {pending_beats, x};
    x.cell_radius = '0;
    x.nucleus_radius = '0;
    pending_beats = {pending_beats, x};
    x = '0;
    x.cell_radius = 31'h7FFF_FFFF;
    x.nucleus_radius = 31'h7FFF_FFFF;
    x.matrix_density = 31'd2;
    x.cell_z = 32'sd1;
    pending_beats = {pending_beats, x};
    x.matrix_density = 31'd1;
    pending_beats = {pending_beats, x};
    for (int i = 0; i < 8; i++) pending_beats = {pending_beats, random_pair()};
  endtask

  task automatic queue_random(int unsigned n);
    repeat (n) pending_beats = {pending_beats, random_pair()};
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_VOXEL_SIZE;
    cfg_data_i = '0;
    voxel_size_q = 31'd1310720;
    gain_q = 31'd65536;
    tiny_q = 16'd1;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    queue_directed();
    queue_random(200);
    drain();

    write_reg(REG_VOXEL_SIZE, '0);
    write_reg(REG_REPULSION_GAIN, 31'h7FFF_FFFF);
    write_reg(REG_TINY_VALUE, 31'h7FFF_FFFF);
    queue_directed();
    queue_random(200);
    drain();

    write_reg(REG_VOXEL_SIZE, 31'h7FFF_FFFF);
    write_reg(REG_REPULSION_GAIN, '0);
    write_reg(REG_TINY_VALUE, '0);
    queue_directed();
    queue_random(150);
    drain();

    write_reg(REG_REPULSION_GAIN, 31'(65536 * 4));
    write_reg(REG_UNMAPPED, 31'($urandom));
    queue_random(200);
    drain();

    for (int p = 0; p < 6; p++) begin
      write_reg(REG_VOXEL_SIZE, 31'($urandom & ((32'd1 << $urandom_range(1, 31)) - 1)));
      write_reg(REG_REPULSION_GAIN, 31'($urandom & ((32'd1 << $urandom_range(1, 31)) - 1)));
      write_reg(REG_TINY_VALUE, 31'($urandom_range(0, 65535)));
      queue_random(180);
      drain();
    end

    $display("Sent %0d beats, checked %0d; %0d applied a push, %0d deformed the nucleus.",
             beats_sent, beats_checked, applied_seen, deform_seen);
    $display("Register writes: %0d; mismatching fields: %0d.", cfg_writes, mismatches);
    if (mismatches == 0 && expected_vel_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timed out with %0d results outstanding.", expected_vel_q.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule

/* sim.f */
hdl/cmrv_pkg.sv
hdl/cmrv_isqrt_pipe.sv
hdl/cmrv_div_pipe.sv
hdl/cmrv_cfg.sv
hdl/cell_matrix_repulsion_velocity_unit.sv
hdl/cmrv_checker.sv
tb/sv/cell_matrix_repulsion_velocity_unit_tb.sv
